// ===== rtl/easing_curve_evaluator_defines.svh =====
// Assertion macros shared by the checkers of the easing curve evaluator.
`ifndef EASING_CURVE_EVALUATOR_DEFINES_SVH
`define EASING_CURVE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ECE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ECE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define ECE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ece_pkg.sv =====
`timescale 1ns / 1ps

package ece_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int QUO_BITS      = FRAC_BITS + 1;
   localparam int CSR_ADDR_BITS = 2;

   typedef logic [CSR_ADDR_BITS-1:0] csr_addr_type;
   typedef logic [1:0]               mode_type;
   typedef logic [QUO_BITS-1:0]      frac_type;

   // register map
   localparam csr_addr_type REG_START = 2'd0;
   localparam csr_addr_type REG_END   = 2'd1;
   localparam csr_addr_type REG_SPAN  = 2'd2;
   localparam csr_addr_type REG_MODE  = 2'd3;

   // curve modes
   localparam mode_type MODE_LINEAR = 2'd0;
   localparam mode_type MODE_IN     = 2'd1;
   localparam mode_type MODE_OUT    = 2'd2;
   localparam mode_type MODE_INOUT  = 2'd3;

   // Q1.16 constants
   localparam frac_type ONE_Q  = frac_type'(1) << FRAC_BITS;
   localparam frac_type HALF_Q = frac_type'(1) << (FRAC_BITS - 1);

endpackage

// ===== rtl/easing_curve_evaluator.sv =====
`timescale 1ns / 1ps

// Channel  Ports                                      Moves
// req      req_valid / req_ready / req_time_point     one time sample per transaction
// rsp      rsp_valid / rsp_ready / rsp_curve_value    one eased value per transaction
// csr      csr_we / csr_addr / csr_wdata              register write, no wait, no read-back
//
// One transaction per clock sustained while rsp_ready is high.
// The pipeline is the restoring divider (one quotient bit per stage, 16 stages)
// followed by the operand select, square, ease, scale, round and saturate stages.
// Synchronous reset clears all valid bits and loads the register defaults.
// A stage advances when rsp_ready is high or it or any later stage is empty, so bubbles
// squeeze out and requests keep entering while a result waits at the output.

module easing_curve_evaluator import ece_pkg::*; #(
   parameter int VALUE_BITS = 16,
   parameter int TIME_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [TIME_BITS-1:0]          req_time_point,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_BITS-1:0]  rsp_curve_value,

   input  logic                          csr_we,
   input  csr_addr_type                  csr_addr,
   input  logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] csr_wdata
);

   localparam int DIV_STEPS  = FRAC_BITS;
   localparam int ST_OPS     = DIV_STEPS + 1;
   localparam int ST_SQUARE  = DIV_STEPS + 2;
   localparam int ST_EASE    = DIV_STEPS + 3;
   localparam int ST_SCALE   = DIV_STEPS + 4;
   localparam int ST_ROUND   = DIV_STEPS + 5;
   localparam int ST_OUT     = DIV_STEPS + 6;
   localparam int NUM_STAGES = DIV_STEPS + 7;

   localparam int OPB_BITS  = QUO_BITS + 1;
   localparam int SQ_BITS   = QUO_BITS + OPB_BITS;
   localparam int PROD_BITS = VALUE_BITS + QUO_BITS + 2;
   localparam int QR_BITS   = PROD_BITS - FRAC_BITS;
   localparam int SUM_BITS  = QR_BITS + 1;

   localparam logic [OPB_BITS-1:0] ONE_B = OPB_BITS'(1) << FRAC_BITS;
   localparam logic [OPB_BITS-1:0] TWO_B = OPB_BITS'(1) << (FRAC_BITS + 1);
   localparam logic signed [PROD_BITS-1:0] RND_BIAS = PROD_BITS'(1) << (FRAC_BITS - 1);
   localparam logic signed [SUM_BITS-1:0] VMAX =
      (SUM_BITS'(1) << (VALUE_BITS - 1)) - SUM_BITS'(1);
   localparam logic signed [SUM_BITS-1:0] VMIN = ~VMAX;

   // square post-processing
   localparam logic [1:0] K_SHR16 = 2'd0;
   localparam logic [1:0] K_SHR15 = 2'd1;
   localparam logic [1:0] K_SUB15 = 2'd2;

   // ---------------- configuration registers ----------------
   logic signed [VALUE_BITS-1:0] start_ff;
   logic signed [VALUE_BITS-1:0] end_ff;
   logic [TIME_BITS-1:0]         span_ff;
   mode_type                     mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         span_ff  <= TIME_BITS'(1);
         mode_ff  <= MODE_INOUT;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_START: start_ff <= csr_wdata[VALUE_BITS-1:0];
            REG_END:   end_ff   <= csr_wdata[VALUE_BITS-1:0];
            REG_SPAN:  span_ff  <= csr_wdata[TIME_BITS-1:0];
            REG_MODE:  mode_ff  <= csr_wdata[1:0];
         endcase
      end
   end

   logic [TIME_BITS-1:0]        dvs;
   logic signed [VALUE_BITS:0]  delta;

   assign dvs   = (span_ff == '0) ? TIME_BITS'(1) : span_ff;
   assign delta = $signed({end_ff[VALUE_BITS-1], end_ff})
                - $signed({start_ff[VALUE_BITS-1], start_ff});

   // ---------------- valid bits and stage enables ----------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] stg_en;

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
      // a stage may load if the output drains or it or some later stage has a hole
      assign stg_en[i] = rsp_ready || !(&vld_ff[NUM_STAGES-1:i]);
   end

   always_comb begin
      vld_in[0] = stg_en[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = stg_en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stg_en[0];
   assign rsp_valid = vld_ff[NUM_STAGES-1];

   // ---------------- restoring divider: u = (tc << 16) / d ----------------
   logic [TIME_BITS-1:0] rem_ff [0:DIV_STEPS-1];
   frac_type             quo_ff [0:DIV_STEPS];

   // top quotient bit is set only when the time reaches the span (clamp)
   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         if (req_time_point >= dvs) begin
            rem_ff[0] <= '0;
            quo_ff[0] <= frac_type'(1);
         end else begin
            rem_ff[0] <= req_time_point;
            quo_ff[0] <= '0;
         end
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [TIME_BITS:0] dbl;
      logic [TIME_BITS:0] dif;
      logic               fit;

      assign dbl = {rem_ff[k-1], 1'b0};
      assign dif = dbl - {1'b0, dvs};
      assign fit = (dbl >= {1'b0, dvs});

      always_ff @(posedge clock) begin
         if (stg_en[k]) begin
            quo_ff[k] <= {quo_ff[k-1][QUO_BITS-2:0], fit};
         end
      end

      if (k < DIV_STEPS) begin : g_rem
         always_ff @(posedge clock) begin
            if (stg_en[k]) begin
               rem_ff[k] <= fit ? dif[TIME_BITS-1:0] : dbl[TIME_BITS-1:0];
            end
         end
      end
   end

   // ---------------- operand select for the square ----------------
   frac_type             frac_u;
   frac_type             opa_in;
   logic [OPB_BITS-1:0]  opb_in;
   logic [1:0]           kind_in;
   frac_type             opa_ff;
   logic [OPB_BITS-1:0]  opb_ff;
   logic [1:0]           kind_ff;

   assign frac_u = quo_ff[DIV_STEPS];

   always_comb begin
      opa_in  = frac_u;
      opb_in  = {1'b0, frac_u};
      kind_in = K_SHR16;
      unique case (mode_ff)
         MODE_LINEAR: begin
            opb_in = ONE_B;                    // u * 1.0
         end
         MODE_IN: begin
            opb_in = {1'b0, frac_u};
         end
         MODE_OUT: begin
            opb_in = TWO_B - {1'b0, frac_u};   // u * (2 - u)
         end
         MODE_INOUT: begin
            if (frac_u < HALF_Q) begin
               kind_in = K_SHR15;
            end else begin
               opa_in  = ONE_Q - frac_u;       // mirrored half
               opb_in  = {1'b0, ONE_Q - frac_u};
               kind_in = K_SUB15;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_en[ST_OPS]) begin
         opa_ff  <= opa_in;
         opb_ff  <= opb_in;
         kind_ff <= kind_in;
      end
   end

   // ---------------- square ----------------
   logic [SQ_BITS-1:0] sq_ff;
   logic [1:0]         sq_kind_ff;

   always_ff @(posedge clock) begin
      if (stg_en[ST_SQUARE]) begin
         sq_ff      <= opa_ff * opb_ff;
         sq_kind_ff <= kind_ff;
      end
   end

   // ---------------- eased fraction ----------------
   frac_type ease_in;
   frac_type ease_ff;

   always_comb begin
      unique case (sq_kind_ff)
         K_SHR16: ease_in = sq_ff[FRAC_BITS +: QUO_BITS];
         K_SHR15: ease_in = sq_ff[FRAC_BITS-1 +: QUO_BITS];
         K_SUB15: ease_in = ONE_Q - sq_ff[FRAC_BITS-1 +: QUO_BITS];
         default: ease_in = sq_ff[FRAC_BITS +: QUO_BITS];
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_en[ST_EASE]) begin
         ease_ff <= ease_in;
      end
   end

   // ---------------- scale by end - start ----------------
   logic signed [PROD_BITS-1:0] scl_ff;

   always_ff @(posedge clock) begin
      if (stg_en[ST_SCALE]) begin
         scl_ff <= delta * $signed({1'b0, ease_ff});
      end
   end

   // ---------------- round half up ----------------
   logic signed [PROD_BITS-1:0] biased;
   logic signed [QR_BITS-1:0]   qr_ff;

   assign biased = scl_ff + RND_BIAS;

   always_ff @(posedge clock) begin
      if (stg_en[ST_ROUND]) begin
         qr_ff <= $signed(biased[PROD_BITS-1:FRAC_BITS]);  // floor shift
      end
   end

   // ---------------- offset and saturate ----------------
   logic signed [SUM_BITS-1:0]   sum;
   logic signed [SUM_BITS-1:0]   sat;
   logic signed [VALUE_BITS-1:0] rsp_curve_value_ff;

   assign sum = $signed({{(SUM_BITS-VALUE_BITS){start_ff[VALUE_BITS-1]}}, start_ff})
              + $signed({qr_ff[QR_BITS-1], qr_ff});

   always_comb begin
      if (sum > VMAX) begin
         sat = VMAX;
      end else if (sum < VMIN) begin
         sat = VMIN;
      end else begin
         sat = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en[ST_OUT]) begin
         rsp_curve_value_ff <= sat[VALUE_BITS-1:0];
      end
   end

   assign rsp_curve_value = rsp_curve_value_ff;

endmodule

// ===== rtl/ece_chk.sv =====
`timescale 1ns / 1ps
`include "easing_curve_evaluator_defines.svh"

module ece_chk import ece_pkg::*; #(
   parameter int VALUE_BITS = 16,
   parameter int TIME_BITS  = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [TIME_BITS-1:0]          req_time_point,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [VALUE_BITS-1:0]  rsp_curve_value,
   input logic                          csr_we,
   input csr_addr_type                  csr_addr,
   input logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] csr_wdata
);

   // response transaction holds until taken
   `ECE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped before accept")
   `ECE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_curve_value), "rsp_curve_value changed while stalled")

   // an empty output stage or a draining output always frees the input
   `ECE_ASSERT_SAME(a_idle_ready, clock, reset, !rsp_valid, req_ready, "req_ready low with empty output")
   `ECE_ASSERT_SAME(a_drain_ready, clock, reset, rsp_ready, req_ready, "req_ready low while output drains")

   // reset empties the pipeline
   `ECE_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready, "pipeline not empty after reset")

endmodule

bind easing_curve_evaluator ece_chk #(
   .VALUE_BITS (VALUE_BITS),
   .TIME_BITS  (TIME_BITS)
) u_ece_chk (.*);
